/* rtl/color_gradient_lut_entry_macros.svh */
// Assertion helpers used by the checker file.
`ifndef COLOR_GRADIENT_LUT_ENTRY_MACROS_SVH
`define COLOR_GRADIENT_LUT_ENTRY_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define CGL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define CGL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define CGL_ASSERT_NXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cgl_pkg.sv */
`timescale 1ns / 1ps

package cgl_pkg;

  localparam int CGL_TABLE_SIZE = 128;
  localparam int CGL_NUM_STOPS  = 7;
  localparam int CGL_IDX_W      = 7;
  localparam int CGL_CH_W       = 8;
  localparam int CGL_COLOR_W    = 24;
  localparam int CGL_CNT_W      = 3;
  localparam int CGL_SEG_W      = 3;
  localparam int CGL_CFG_IDX_W  = 3;
  localparam int CGL_CFG_DATA_W = 24;

  localparam logic [CGL_CFG_IDX_W-1:0] CGL_REG_STOP_COUNT  = 3'd0;
  localparam logic [CGL_CFG_IDX_W-1:0] CGL_REG_STOP_COLOR0 = 3'd1;

  // stage load enables for the index front end
  typedef struct packed {
    logic cap;
    logic seg;
  } cgl_front_adv_t;

  // stage load enables for one color lane
  typedef struct packed {
    logic prod;
    logic est;
    logic fix;
    logic out;
  } cgl_lane_adv_t;

endpackage

/* rtl/cgl_if.sv */
`timescale 1ns / 1ps

interface cgl_in_if
  import cgl_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CGL_IDX_W-1:0] table_index;

  modport source (output valid, output table_index, input ready);
  modport sink   (input valid, input table_index, output ready);
endinterface

interface cgl_out_if
  import cgl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CGL_CH_W-1:0] red;
  logic [CGL_CH_W-1:0] green;
  logic [CGL_CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* rtl/color_gradient_lut_entry.sv */
`timescale 1ns / 1ps
// Multi-stop linear color gradient lookup.
// in_ch carries one table_index per beat; out_ch returns red/green/blue for
// it. Beats complete on valid && ready. Config (cfg_we/cfg_index/cfg_wdata):
// index 0 is stop_count, indexes 1..7 are the packed 0xRRGGBB color stops.
// Write config only while nothing is in flight.
// Pipeline: an input beat reaches out_ch through seven register stages:
// scale, segment, stop read, multiply, reciprocal estimate, fix-up and
// output register.
// Throughput: one index per clock while out_ch does not stall; every stage holds its own valid bit.
// Stall: when out_ch.ready is low the output register holds; upstream
// stages keep filling empty slots, so in_ch.ready drops only once all
// seven stages hold data.
// Reset: all valid bits clear, stop_count and all color stops read as zero
// (black output) until written.
module color_gradient_lut_entry
  import cgl_pkg::*;
#(
  parameter int TABLE_SIZE = CGL_TABLE_SIZE
) (
  input  logic                      clk,
  input  logic                      rst_n,
  cgl_in_if.sink                    in_ch,
  cgl_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [CGL_CFG_IDX_W-1:0]  cfg_index,
  input  logic [CGL_CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RW     = $clog2(TABLE_SIZE);
  localparam int STAGES = 7;

  logic [STAGES:1]      vld_r;
  logic [STAGES:1]      en;
  cgl_front_adv_t       front_adv;
  cgl_lane_adv_t        lane_adv;

  logic [CGL_CNT_W-1:0]   stop_count_r;
  logic [CGL_COLOR_W-1:0] col_mem [CGL_NUM_STOPS];
  logic [CGL_NUM_STOPS-1:0] col_ok_r;
  logic [CGL_SEG_W-1:0]   col_waddr;

  logic [CGL_SEG_W-1:0] seg, seg_nx;
  logic [RW-1:0]        seg_r_val;
  logic                 blank;

  logic [CGL_COLOR_W-1:0] rd0_r, rd1_r;
  logic                   ok0_r, ok1_r;
  logic [RW-1:0]          r3_r;
  logic [CGL_COLOR_W-1:0] a_col, b_col;
  logic [CGL_CH_W-1:0]    lane_q [3];

  // per-stage advance: a stage loads when it is empty or its successor loads
  always_comb begin
    en[STAGES] = !vld_r[STAGES] || out_ch.ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) begin
        vld_r[1] <= in_ch.valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign front_adv.cap = en[1];
  assign front_adv.seg = en[2];
  assign lane_adv.prod = en[4];
  assign lane_adv.est  = en[5];
  assign lane_adv.fix  = en[6];
  assign lane_adv.out  = en[7];

  assign in_ch.ready  = en[1];
  assign out_ch.valid = vld_r[STAGES];

  // configuration
  assign col_waddr = cfg_index - CGL_REG_STOP_COLOR0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= '0;
      col_ok_r     <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CGL_REG_STOP_COUNT) begin
        stop_count_r <= cfg_wdata[CGL_CNT_W-1:0];
      end else begin
        col_ok_r[col_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we && cfg_index != CGL_REG_STOP_COUNT) begin
      col_mem[col_waddr] <= cfg_wdata[CGL_COLOR_W-1:0];
    end
  end

  cgl_index #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_index (
    .clk         (clk),
    .adv         (front_adv),
    .table_index (in_ch.table_index),
    .stop_count  (stop_count_r),
    .seg_o       (seg),
    .seg_nx_o    (seg_nx),
    .r_o         (seg_r_val),
    .blank_o     (blank)
  );

  // stage 3: read both end stops; unwritten stops read as black
  always_ff @(posedge clk) begin
    if (en[3]) begin
      rd0_r <= col_mem[seg];
      rd1_r <= col_mem[seg_nx];
      ok0_r <= col_ok_r[seg] && !blank;
      ok1_r <= col_ok_r[seg_nx] && !blank;
      r3_r  <= seg_r_val;
    end
  end

  assign a_col = ok0_r ? rd0_r : '0;
  assign b_col = ok1_r ? rd1_r : '0;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    cgl_lane #(
      .TABLE_SIZE (TABLE_SIZE)
    ) u_lane (
      .clk (clk),
      .adv (lane_adv),
      .a_i (a_col[CGL_COLOR_W-1-CGL_CH_W*c -: CGL_CH_W]),
      .b_i (b_col[CGL_COLOR_W-1-CGL_CH_W*c -: CGL_CH_W]),
      .r_i (r3_r),
      .q_o (lane_q[c])
    );
  end

  assign out_ch.red   = lane_q[0];
  assign out_ch.green = lane_q[1];
  assign out_ch.blue  = lane_q[2];

endmodule

/* rtl/cgl_index.sv */
`timescale 1ns / 1ps

module cgl_index
  import cgl_pkg::*;
#(
  parameter int TABLE_SIZE = CGL_TABLE_SIZE
) (
  input  logic                         clk,
  input  cgl_front_adv_t               adv,
  input  logic [CGL_IDX_W-1:0]         table_index,
  input  logic [CGL_CNT_W-1:0]         stop_count,
  output logic [CGL_SEG_W-1:0]         seg_o,
  output logic [CGL_SEG_W-1:0]         seg_nx_o,
  output logic [$clog2(TABLE_SIZE)-1:0] r_o,
  output logic                         blank_o
);

  localparam int SPAN = TABLE_SIZE - 1;
  localparam int RW   = $clog2(TABLE_SIZE);
  localparam int SW   = RW + 3;

  logic [RW-1:0]        idx_sat;
  logic [CGL_CNT_W-1:0] nm1;
  logic [SW-1:0]        scaled_nxt, scaled_r;
  logic [CGL_SEG_W-1:0] ge_cnt, seg_max, seg;
  logic [SW-1:0]        rem;
  logic [CGL_SEG_W-1:0] seg_nxt, seg_nx_nxt;
  logic [RW-1:0]        r_nxt;
  logic                 multi;

  assign multi = (stop_count >= 3'd2);

  // stage 1: clamp the index and scale by the number of segments
  always_comb begin
    idx_sat    = (int'(table_index) > SPAN) ? RW'(SPAN) : RW'(table_index);
    nm1        = multi ? (stop_count - 3'd1) : '0;
    scaled_nxt = SW'(idx_sat) * SW'(nm1);
  end

  always_ff @(posedge clk) begin
    if (adv.cap) begin
      scaled_r <= scaled_nxt;
    end
  end

  // stage 2: segment by threshold compares, remainder by constant multiply
  always_comb begin
    ge_cnt = '0;
    for (int k = 1; k < CGL_NUM_STOPS; k++) begin
      if (scaled_r >= SW'(k * SPAN)) begin
        ge_cnt = ge_cnt + 3'd1;
      end
    end
    seg_max = stop_count - 3'd2;
    if (!multi) begin
      seg = '0;
    end else if (ge_cnt > seg_max) begin
      seg = seg_max;
    end else begin
      seg = ge_cnt;
    end
    rem        = scaled_r - SW'(seg) * SW'(SPAN);
    r_nxt      = multi ? rem[RW-1:0] : '0;
    seg_nxt    = seg;
    seg_nx_nxt = multi ? (seg + 3'd1) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv.seg) begin
      seg_o    <= seg_nxt;
      seg_nx_o <= seg_nx_nxt;
      r_o      <= r_nxt;
      blank_o  <= (stop_count == '0);
    end
  end

endmodule

/* rtl/cgl_lane.sv */
`timescale 1ns / 1ps

module cgl_lane
  import cgl_pkg::*;
#(
  parameter int TABLE_SIZE = CGL_TABLE_SIZE
) (
  input  logic                          clk,
  input  cgl_lane_adv_t                 adv,
  input  logic [CGL_CH_W-1:0]           a_i,
  input  logic [CGL_CH_W-1:0]           b_i,
  input  logic [$clog2(TABLE_SIZE)-1:0] r_i,
  output logic [CGL_CH_W-1:0]           q_o
);

  localparam int SPAN  = TABLE_SIZE - 1;
  localparam int RW    = $clog2(TABLE_SIZE);
  localparam int PW    = CGL_CH_W + RW;
  localparam int K     = PW + 1;
  localparam int RECIP = (2 ** K) / SPAN;
  localparam logic [K:0] RECIP_V = (K + 1)'(RECIP);

  logic                neg;
  logic [CGL_CH_W-1:0] diff;
  logic [PW-1:0]       prod_nxt, prod_r, prod5_r;
  logic [CGL_CH_W-1:0] a4_r, a5_r, a6_r;
  logic                neg4_r, neg5_r, neg6_r;
  logic [PW+K:0]       mul;
  logic [CGL_CH_W-1:0] est_nxt, est_r;
  logic [PW-1:0]       chk, rem;
  logic [CGL_CH_W-1:0] q_nxt, q_r;
  logic [CGL_CH_W-1:0] out_nxt, out_r;

  // stage 4: magnitude of the step times the remainder
  always_comb begin
    neg      = (b_i < a_i);
    diff     = neg ? (a_i - b_i) : (b_i - a_i);
    prod_nxt = PW'(diff) * PW'(r_i);
  end

  always_ff @(posedge clk) begin
    if (adv.prod) begin
      prod_r <= prod_nxt;
      a4_r   <= a_i;
      neg4_r <= neg;
    end
  end

  // stage 5: quotient estimate by reciprocal, low by at most one
  always_comb begin
    mul     = (PW + K + 1)'(prod_r) * (PW + K + 1)'(RECIP_V);
    est_nxt = mul[K+CGL_CH_W-1:K];
  end

  always_ff @(posedge clk) begin
    if (adv.est) begin
      est_r   <= est_nxt;
      prod5_r <= prod_r;
      a5_r    <= a4_r;
      neg5_r  <= neg4_r;
    end
  end

  // stage 6: fix up the estimate from the remainder
  always_comb begin
    chk   = PW'(est_r) * PW'(SPAN);
    rem   = prod5_r - chk;
    q_nxt = (rem >= PW'(SPAN)) ? (est_r + 8'd1) : est_r;
  end

  always_ff @(posedge clk) begin
    if (adv.fix) begin
      q_r    <= q_nxt;
      a6_r   <= a5_r;
      neg6_r <= neg5_r;
    end
  end

  // stage 7: apply toward the end stop
  assign out_nxt = neg6_r ? (a6_r - q_r) : (a6_r + q_r);

  always_ff @(posedge clk) begin
    if (adv.out) begin
      out_r <= out_nxt;
    end
  end

  assign q_o = out_r;

endmodule

/* rtl/cgl_checker.sv */
`timescale 1ns / 1ps
`include "color_gradient_lut_entry_macros.svh"

module cgl_checker
  import cgl_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [CGL_CH_W-1:0] out_red,
  input logic [CGL_CH_W-1:0] out_green,
  input logic [CGL_CH_W-1:0] out_blue
);

  // a held result beat stays up
  `CGL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "out beat dropped while stalled")

  // and its color does not move
  `CGL_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable({out_red, out_green, out_blue}), "out payload changed while stalled")

  // backpressure only when the result side is actually blocked
  `CGL_ASSERT_IMP(a_in_ready, !out_valid || out_ready, in_ready, "input stalled with output free")

  // reset empties the pipe
  `CGL_ASSERT_NXT_RST(a_rst_empty, !rst_n, !out_valid, "result beat right after reset")

  // an input refused while valid means the result side is stalled
  `CGL_ASSERT_IMP(a_accept_rdy, in_valid && !in_ready, out_valid && !out_ready, "input refused without a stall")

endmodule

bind color_gradient_lut_entry cgl_checker u_cgl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.red),
  .out_green (out_ch.green),
  .out_blue  (out_ch.blue)
);
